// File: rtl/core/mcfp_pkg.sv
// Package: character codes, status codes and the byte class bundle for the frame parser.
`timescale 1ns / 1ps
`default_nettype none

package mcfp_pkg;

  localparam logic [7:0] CH_0       = 8'h30;  // '0'
  localparam logic [7:0] CH_1       = 8'h31;  // '1'
  localparam logic [7:0] CH_4       = 8'h34;  // '4'
  localparam logic [7:0] CH_9       = 8'h39;  // '9'
  localparam logic [7:0] CH_E_UP    = 8'h45;  // 'E'
  localparam logic [7:0] CH_E_LO    = 8'h65;  // 'e'
  localparam logic [7:0] CH_F_UP    = 8'h46;  // 'F'
  localparam logic [7:0] CH_F_LO    = 8'h66;  // 'f'
  localparam logic [7:0] CH_B_UP    = 8'h42;  // 'B'
  localparam logic [7:0] CH_B_LO    = 8'h62;  // 'b'
  localparam logic [7:0] CH_L_UP    = 8'h4C;  // 'L'
  localparam logic [7:0] CH_L_LO    = 8'h6C;  // 'l'
  localparam logic [7:0] CH_R_UP    = 8'h52;  // 'R'
  localparam logic [7:0] CH_R_LO    = 8'h72;  // 'r'

  localparam logic [2:0] FRAME_LAST = 3'd7;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EARLY_END = 2'd1;
  localparam logic [1:0] STATUS_NO_END    = 2'd2;
  localparam logic [1:0] STATUS_BAD_FIELD = 2'd3;

  localparam logic [7:0] SPEED_MAX = 8'd199;
  localparam logic [5:0] ANGLE_MAX = 6'd49;

  // Classification of one received byte
  typedef struct packed {
    logic       term;      // E or e
    logic       dig1_ok;   // '0'..'1'
    logic       dig4_ok;   // '0'..'4'
    logic       dig9_ok;   // '0'..'9'
    logic [3:0] digit;     // digit value, meaningful when dig9_ok
    logic       dir_f;
    logic       dir_b;
    logic       side_l;
    logic       side_r;
  } byte_class_t;

endpackage

`default_nettype wire

// File: rtl/core/mcfp_byte_decode.sv
// Byte classifier: terminator, digit ranges and letter codes of one byte.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_byte_decode (
  input  wire logic [7:0]          rx_byte,
  output mcfp_pkg::byte_class_t    cls
);

  logic ge0;

  assign ge0 = (rx_byte >= mcfp_pkg::CH_0);

  always_comb begin
    cls.term    = (rx_byte == mcfp_pkg::CH_E_UP) || (rx_byte == mcfp_pkg::CH_E_LO);
    cls.dig1_ok = ge0 && (rx_byte <= mcfp_pkg::CH_1);
    cls.dig4_ok = ge0 && (rx_byte <= mcfp_pkg::CH_4);
    cls.dig9_ok = ge0 && (rx_byte <= mcfp_pkg::CH_9);
    // ASCII digits sit at 0x30, so the low nibble is the value
    cls.digit   = rx_byte[3:0];
    cls.dir_f   = (rx_byte == mcfp_pkg::CH_F_UP) || (rx_byte == mcfp_pkg::CH_F_LO);
    cls.dir_b   = (rx_byte == mcfp_pkg::CH_B_UP) || (rx_byte == mcfp_pkg::CH_B_LO);
    cls.side_l  = (rx_byte == mcfp_pkg::CH_L_UP) || (rx_byte == mcfp_pkg::CH_L_LO);
    cls.side_r  = (rx_byte == mcfp_pkg::CH_R_UP) || (rx_byte == mcfp_pkg::CH_R_LO);
  end

endmodule

`default_nettype wire

// File: rtl/core/mcfp_frame.sv
// Frame state and result register: per-position field checks and frame-end status.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_frame (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,      // a byte is processed this cycle
  input  wire logic                  advance,   // result register may be loaded
  input  wire mcfp_pkg::byte_class_t cls,
  output logic                       out_valid,
  output logic [1:0]                 status,
  output logic [7:0]                 speed,
  output logic                       forward,
  output logic [5:0]                 angle,
  output logic                       left
);

  logic [2:0] byte_position, byte_position_next;
  logic       fields_ok, fields_ok_next;
  logic [7:0] speed_acc, speed_acc_next;
  logic       dir_forward, dir_forward_next;
  logic [5:0] angle_acc, angle_acc_next;
  logic       side_left, side_left_next;

  logic       frame_end;
  logic [1:0] status_next;
  logic [7:0] digit8;
  logic [7:0] digit_x10;

  assign digit8    = {4'd0, cls.digit};
  assign digit_x10 = {digit8[4:0], 3'd0} + {digit8[6:0], 1'b0};

  always_comb begin
    byte_position_next = byte_position;
    fields_ok_next     = fields_ok;
    speed_acc_next     = speed_acc;
    dir_forward_next   = dir_forward;
    angle_acc_next     = angle_acc;
    side_left_next     = side_left;
    frame_end          = 1'b0;
    status_next        = mcfp_pkg::STATUS_OK;

    if (byte_position == mcfp_pkg::FRAME_LAST) begin
      frame_end = 1'b1;
      priority if (!cls.term) begin
        status_next = mcfp_pkg::STATUS_NO_END;
      end else if (!fields_ok) begin
        status_next = mcfp_pkg::STATUS_BAD_FIELD;
      end else begin
        status_next = mcfp_pkg::STATUS_OK;
      end
    end else if (cls.term) begin
      frame_end   = 1'b1;
      status_next = mcfp_pkg::STATUS_EARLY_END;
    end else begin
      byte_position_next = byte_position + 3'd1;
      unique case (byte_position)
        3'd0: begin
          if (cls.dig1_ok) speed_acc_next = cls.digit[0] ? 8'd100 : 8'd0;
          else fields_ok_next = 1'b0;
        end
        3'd1: begin
          if (cls.dig9_ok) speed_acc_next = speed_acc + digit_x10;
          else fields_ok_next = 1'b0;
        end
        3'd2: begin
          if (cls.dig9_ok) speed_acc_next = speed_acc + digit8;
          else fields_ok_next = 1'b0;
        end
        3'd3: begin
          priority if (cls.dir_f) dir_forward_next = 1'b1;
          else if (cls.dir_b) dir_forward_next = 1'b0;
          else fields_ok_next = 1'b0;
        end
        3'd4: begin
          if (cls.dig4_ok) angle_acc_next = digit_x10[5:0];
          else fields_ok_next = 1'b0;
        end
        3'd5: begin
          if (cls.dig9_ok) angle_acc_next = angle_acc + {2'd0, cls.digit};
          else fields_ok_next = 1'b0;
        end
        default: begin
          priority if (cls.side_l) side_left_next = 1'b1;
          else if (cls.side_r) side_left_next = 1'b0;
          else fields_ok_next = 1'b0;
        end
      endcase
    end

    if (frame_end) begin
      byte_position_next = 3'd0;
      fields_ok_next     = 1'b1;
      speed_acc_next     = 8'd0;
      dir_forward_next   = 1'b0;
      angle_acc_next     = 6'd0;
      side_left_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      fields_ok     <= 1'b1;
      speed_acc     <= 8'd0;
      dir_forward   <= 1'b0;
      angle_acc     <= 6'd0;
      side_left     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        byte_position <= byte_position_next;
        fields_ok     <= fields_ok_next;
        speed_acc     <= speed_acc_next;
        dir_forward   <= dir_forward_next;
        angle_acc     <= angle_acc_next;
        side_left     <= side_left_next;
      end
      if (advance) begin
        out_valid <= fire && frame_end;
      end
    end
  end

  // Result payload, zeroed on any rejected frame
  always_ff @(posedge clk) begin
    if (advance && fire && frame_end) begin
      status <= status_next;
      if (status_next == mcfp_pkg::STATUS_OK) begin
        speed   <= speed_acc;
        forward <= dir_forward;
        angle   <= angle_acc;
        left    <= side_left;
      end else begin
        speed   <= 8'd0;
        forward <= 1'b0;
        angle   <= 6'd0;
        left    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/motor_command_frame_parser.sv
// Top level of the motor command frame parser: input register, byte decode, frame logic.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, rx_byte[7:0]     | byte in
//  out     | out_valid, out_stall, status[1:0],   | result out
//          | speed[7:0], forward, angle[5:0], left|
//
// One byte per cycle while the result is not stalled. A byte waits in the input
// register, then is checked against its frame position and folded into the
// frame state; a frame-end result enters the output register in that cycle.
// Synchronous active-high reset clears the frame state and both valid flags.
// A stalled result holds the frame logic; the input register still takes one
// more byte, and in_stall rises only when that register is also full.
`timescale 1ns / 1ps
`default_nettype none

module motor_command_frame_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [7:0]      speed,
  output logic            forward,
  output logic [5:0]      angle,
  output logic            left
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // The frame stage moves when the result register is empty or being taken
  logic advance;
  logic fire;
  logic in_take;

  mcfp_pkg::byte_class_t cls;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  mcfp_byte_decode u_decode (
    .rx_byte (s1_byte),
    .cls     (cls)
  );

  mcfp_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .advance   (advance),
    .cls       (cls),
    .out_valid (out_valid),
    .status    (status),
    .speed     (speed),
    .forward   (forward),
    .angle     (angle),
    .left      (left)
  );

endmodule

`default_nettype wire

// File: rtl/core/mcfp_checker.sv
// Port-level checker for the motor command frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] rx_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status,
  input wire logic [7:0] speed,
  input wire logic       forward,
  input wire logic [5:0] angle,
  input wire logic       left
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Input backpressure only while the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // Rejected frames carry zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != mcfp_pkg::STATUS_OK) |->
      (speed == 8'd0 && angle == 6'd0 && !forward && !left))
    else $error("rejected frame with nonzero fields");

  // Accepted frames stay within field ranges
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mcfp_pkg::STATUS_OK) |->
      (speed <= mcfp_pkg::SPEED_MAX && angle <= mcfp_pkg::ANGLE_MAX))
    else $error("accepted frame out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(speed) && $stable(forward)
       && $stable(angle) && $stable(left)))
    else $error("stalled result changed");

endmodule

bind motor_command_frame_parser mcfp_checker u_mcfp_checker (.*);

`default_nettype wire
